@@ sv/rkce_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rkce_pkg
// Shared types and codes of the replicated key coherence engine.
// ----------------------------------------------------------------------------
package rkce_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_ID = 2'd0,
    CFG_ALIVE   = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CMD_READ  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_INV   = 3'd2,
    CMD_ACK   = 3'd3,
    CMD_VAL   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    KS_VALID     = 3'd0,
    KS_INVALID   = 3'd1,
    KS_WRITE     = 3'd2,
    KS_INV_WRITE = 3'd3,
    KS_REPLAY    = 3'd4
  } key_state_e;

  typedef enum logic [3:0] {
    RS_GET_DONE  = 4'd0,
    RS_GET_STALL = 4'd1,
    RS_REPLAY    = 4'd2,
    RS_RETRY     = 4'd3,
    RS_PUT_OK    = 4'd4,
    RS_PUT_STALL = 4'd5,
    RS_INV_OK    = 4'd6,
    RS_INV_OOG   = 4'd7,
    RS_ACK_OK    = 4'd8,
    RS_LAST_ACK  = 4'd9,
    RS_VAL_OK    = 4'd10
  } rsp_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [9:0]  key_index;
    logic [31:0] ts_version;
    logic [2:0]  ts_tie;
    logic [2:0]  sender;
    logic [63:0] data_in;
    logic [5:0]  buffer_slot;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [63:0] data_out;
    logic [31:0] out_version;
    logic [2:0]  out_tie;
    logic        completed;
    logic [5:0]  completed_slot;
  } out_word_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_full;
  } dp_status_t;

endpackage
`default_nettype wire

@@ sv/rkce_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rkce_in_if
// Input channel: valid/ready handshake carrying one command word.
// ----------------------------------------------------------------------------
interface rkce_in_if;
  logic              valid;
  logic              ready;
  rkce_pkg::in_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ sv/rkce_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rkce_out_if
// Output channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface rkce_out_if;
  logic               valid;
  logic               ready;
  rkce_pkg::out_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ sv/rkce_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rkce_ctrl
// Sequencer: table clear after reset, then accept / execute per word.
// ----------------------------------------------------------------------------
module rkce_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 out_ready_i,
  input  wire rkce_pkg::dp_status_t status_i,
  output rkce_pkg::ctrl_cmd_t       cmd_o
);
  import rkce_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o    = (state_q == S_IDLE);
  assign cmd_o.clear   = (state_q == S_CLEAR);
  assign cmd_o.accept  = in_valid_i && in_ready_o;
  assign cmd_o.commit  = (state_q == S_EXEC) && (!status_i.out_full || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (status_i.clear_last) state_d = S_IDLE;
      S_IDLE:  if (cmd_o.accept) state_d = S_EXEC;
      S_EXEC:  if (cmd_o.commit) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == S_EXEC)
    else $error("accept did not lead to exec");
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear |-> !in_ready_o)
    else $error("ready during clear");
  a_commit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> state_q == S_IDLE)
    else $error("commit did not return to idle");

endmodule
`default_nettype wire

@@ sv/rkce_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rkce_dp
// Key table memory, config registers, per-command update and result register.
// ----------------------------------------------------------------------------
module rkce_dp #(
  parameter int unsigned KEY_SLOTS    = 1024,
  parameter int unsigned VALUE_BITS   = 64,
  parameter int unsigned NODES        = 8,
  parameter int unsigned BUFFER_SLOTS = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [rkce_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [rkce_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire rkce_pkg::in_word_t               in_word_i,
  input  wire rkce_pkg::ctrl_cmd_t              cmd_i,
  input  wire logic                             out_ready_i,
  output logic                                  out_valid_o,
  output rkce_pkg::out_word_t                   out_word_o,
  output rkce_pkg::dp_status_t                  status_o
);
  import rkce_pkg::*;

  localparam int unsigned AW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int unsigned PW = $clog2(BUFFER_SLOTS + 1);

  typedef struct packed {
    logic [2:0]            kstate;
    logic [31:0]           version;
    logic [2:0]            tie;
    logic [2:0]            writer;
    logic [VALUE_BITS-1:0] value;
    logic [PW-1:0]         pslot;
    logic [31:0]           own_version;
    logic [2:0]            own_tie;
    logic [NODES-1:0]      acks;
  } entry_t;

  entry_t mem [KEY_SLOTS];
  entry_t rd_q, nxt, rst_entry;
  in_word_t item_q;
  logic [2:0] node_id_q;
  logic [7:0] alive_q;
  logic [AW:0] clr_q;
  logic [AW-1:0] rd_addr, addr_q;
  logic [30:0] red;
  logic out_valid_q;
  out_word_t out_q, res;

  always_comb begin
    red = 31'(in_word_i.key_index);
    for (int s = 9; s >= 0; s--) begin
      if (red >= (31'(KEY_SLOTS) << s)) red = red - (31'(KEY_SLOTS) << s);
    end
    rd_addr = red[AW-1:0];
  end

  always_comb begin
    rst_entry        = '0;
    rst_entry.kstate = KS_VALID;
    rst_entry.pslot  = PW'(BUFFER_SLOTS);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem[clr_q[AW-1:0]] <= rst_entry;
    end else if (cmd_i.commit) begin
      mem[addr_q] <= nxt;
    end
    if (cmd_i.accept) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_word_i;
      addr_q <= rd_addr;
    end
    if (cmd_i.commit) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      node_id_q   <= '0;
      alive_q     <= 8'hff;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + 1'b1;
      if (cfg_we_i && cfg_idx_i == CFG_NODE_ID) node_id_q <= cfg_data_i[2:0];
      if (cfg_we_i && cfg_idx_i == CFG_ALIVE) alive_q <= cfg_data_i;
      if (cmd_i.commit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign status_o.clear_last = (clr_q == (AW+1)'(KEY_SLOTS - 1));
  assign status_o.out_full   = out_valid_q;
  assign out_valid_o         = out_valid_q;
  assign out_word_o          = out_q;

  logic [NODES-1:0] alive_n, remote, alive_sh, acks_new;
  logic [7:0] pslot8, slot8;
  logic busy, slot_ok, ts_lt, ts_eq, own_eq;
  logic [31:0] nv;

  always_comb begin
    alive_n  = alive_q[NODES-1:0];
    remote   = alive_n & ~(NODES'(1) << node_id_q);
    alive_sh = alive_n >> rd_q.writer;
    acks_new = rd_q.acks & ~(NODES'(1) << item_q.sender);
    pslot8   = 8'(rd_q.pslot);
    slot8    = 8'(item_q.buffer_slot);
    busy     = pslot8 < 8'(BUFFER_SLOTS);
    slot_ok  = slot8 < 8'(BUFFER_SLOTS);
    ts_lt    = (rd_q.version < item_q.ts_version) ||
               (rd_q.version == item_q.ts_version && rd_q.tie < item_q.ts_tie);
    ts_eq    = (rd_q.version == item_q.ts_version) && (rd_q.tie == item_q.ts_tie);
    own_eq   = (rd_q.own_version == item_q.ts_version) && (rd_q.own_tie == item_q.ts_tie);
    nv       = rd_q.version + 32'd2;

    nxt = rd_q;
    res = '0;
    res.status = RS_RETRY;
    case (item_q.command)
      CMD_READ: begin
        if (rd_q.kstate == KS_VALID) begin
          res.status   = RS_GET_DONE;
          res.data_out = 64'(rd_q.value);
        end else if (rd_q.kstate != KS_INVALID) begin
          res.status = RS_GET_STALL;
        end else if (alive_sh[0]) begin
          res.status = RS_GET_STALL;
        end else if (!busy && slot_ok) begin
          nxt.kstate      = KS_REPLAY;
          nxt.pslot       = PW'(slot8);
          nxt.own_version = rd_q.version;
          nxt.own_tie     = rd_q.tie;
          nxt.acks        = remote;
          res.status      = RS_REPLAY;
          res.data_out    = 64'(rd_q.value);
          res.out_version = rd_q.version;
          res.out_tie     = rd_q.tie;
        end
      end
      CMD_WRITE: begin
        if ((rd_q.kstate == KS_VALID || rd_q.kstate == KS_INVALID) && !busy) begin
          if (slot_ok) begin
            nxt.kstate      = KS_WRITE;
            nxt.value       = item_q.data_in[VALUE_BITS-1:0];
            nxt.acks        = remote;
            nxt.pslot       = PW'(slot8);
            nxt.version     = nv;
            nxt.tie         = node_id_q;
            nxt.own_version = nv;
            nxt.own_tie     = node_id_q;
            res.status      = RS_PUT_OK;
            res.out_version = nv;
            res.out_tie     = node_id_q;
          end
        end else begin
          res.status = RS_PUT_STALL;
        end
      end
      CMD_INV: begin
        res.status = RS_INV_OK;
        if (ts_lt) begin
          nxt.writer  = item_q.sender;
          nxt.value   = item_q.data_in[VALUE_BITS-1:0];
          nxt.version = item_q.ts_version;
          nxt.tie     = item_q.ts_tie;
          if (rd_q.kstate == KS_VALID) nxt.kstate = KS_INVALID;
          else if (rd_q.kstate == KS_WRITE || rd_q.kstate == KS_REPLAY)
            nxt.kstate = KS_INV_WRITE;
        end else if (ts_eq) begin
          if (rd_q.kstate == KS_WRITE) res.status = RS_INV_OOG;
          nxt.writer = item_q.sender;
        end
      end
      CMD_ACK: begin
        res.status = RS_ACK_OK;
        if (own_eq) begin
          nxt.acks = acks_new;
          if ((acks_new & alive_n) == '0 && busy) begin
            res.completed      = 1'b1;
            res.completed_slot = pslot8[5:0];
            nxt.pslot          = PW'(BUFFER_SLOTS);
            if (rd_q.kstate == KS_INV_WRITE) begin
              nxt.kstate = KS_INVALID;
            end else if (rd_q.kstate == KS_WRITE || rd_q.kstate == KS_REPLAY) begin
              nxt.kstate = KS_VALID;
              res.status = RS_LAST_ACK;
            end
          end
        end
      end
      CMD_VAL: begin
        res.status = RS_VAL_OK;
        if (ts_eq) nxt.kstate = KS_VALID;
      end
      default: res.status = RS_RETRY;
    endcase
  end

  a_commit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("result lost on commit");
  a_no_clear_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.clear && (cmd_i.commit || cmd_i.accept)))
    else $error("item work during clear");
  a_commit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten");

endmodule
`default_nettype wire

@@ sv/replicated_key_coherence_engine_top.sv @@
`default_nettype none
// A word is taken only in idle; its key table entry is read into a register,
// and the result is registered on commit, which waits while the output is full.
// A new word is not taken until the last one's result is committed, with the
// key table read at accept and its write-back at commit.
// Reset: resets control and config; the table is then swept to its reset
// entry, during which no word is taken.
// ----------------------------------------------------------------------------
// replicated_key_coherence_engine_top
// Per-key replica state table of an invalidation-based replication scheme.
// ----------------------------------------------------------------------------
module replicated_key_coherence_engine_top #(
  parameter int unsigned KEY_SLOTS    = 1024,
  parameter int unsigned VALUE_BITS   = 64,
  parameter int unsigned NODES        = 8,
  parameter int unsigned BUFFER_SLOTS = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [rkce_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [rkce_pkg::CFG_DATA_W-1:0] cfg_data_i,
  rkce_in_if.sink                              in_i,
  rkce_out_if.source                           out_o
);
  import rkce_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  rkce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rkce_dp #(
    .KEY_SLOTS    (KEY_SLOTS),
    .VALUE_BITS   (VALUE_BITS),
    .NODES        (NODES),
    .BUFFER_SLOTS (BUFFER_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_i.payload),
    .cmd_i       (cmd),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_word_o  (out_o.payload),
    .status_o    (status)
  );

endmodule
`default_nettype wire

@@ tb/replicated_key_coherence_engine_top_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// replicated_key_coherence_engine_top_tb
// Drives command words through the key table across several node-id and
// membership settings. A local copy of the table predicts each result word,
// which is compared as a whole word. Both channels idle at random outside calm phases.
// ----------------------------------------------------------------------------
module replicated_key_coherence_engine_top_tb;
  import rkce_pkg::*;

  localparam int KEYS = 1024;
  localparam int SLOTS = 64;
  localparam int KEY_POOL = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  rkce_in_if in_ch ();
  rkce_out_if out_ch ();

  replicated_key_coherence_engine_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  always #6 clk_i = ~clk_i;

  key_state_e  tbl_state [KEYS];
  logic [31:0] tbl_ver [KEYS];
  logic [2:0]  tbl_tie [KEYS];
  logic [2:0]  tbl_writer [KEYS];
  logic [63:0] tbl_value [KEYS];
  logic [6:0]  tbl_slot [KEYS];
  logic [31:0] tbl_own_ver [KEYS];
  logic [2:0]  tbl_own_tie [KEYS];
  logic [7:0]  tbl_acks [KEYS];
  logic [2:0]  node_id;
  logic [7:0]  alive;

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit in_fire = 1'b0;

  function automatic logic [7:0] remote_nodes();
    logic [7:0] m;
    m = alive;
    m[node_id] = 1'b0;
    return m;
  endfunction

  function automatic out_word_t apply_word(in_word_t w);
    out_word_t r;
    int k;
    key_state_e st;
    bit busy;
    bit newer;
    k = w.key_index;
    st = tbl_state[k];
    busy = tbl_slot[k] < SLOTS;
    newer = tbl_ver[k] < w.ts_version ||
            (tbl_ver[k] == w.ts_version && tbl_tie[k] < w.ts_tie);
    r = '0;
    r.status = RS_RETRY;
    case (w.command)
      CMD_READ: begin
        if (st == KS_VALID) begin
          r.status = RS_GET_DONE;
          r.data_out = tbl_value[k];
        end else if (st != KS_INVALID || alive[tbl_writer[k]]) begin
          r.status = RS_GET_STALL;
        end else if (!busy) begin
          tbl_state[k] = KS_REPLAY;
          tbl_slot[k] = {1'b0, w.buffer_slot};
          tbl_own_ver[k] = tbl_ver[k];
          tbl_own_tie[k] = tbl_tie[k];
          tbl_acks[k] = remote_nodes();
          r.status = RS_REPLAY;
          r.data_out = tbl_value[k];
          r.out_version = tbl_ver[k];
          r.out_tie = tbl_tie[k];
        end
      end
      CMD_WRITE: begin
        if ((st == KS_VALID || st == KS_INVALID) && !busy) begin
          tbl_state[k] = KS_WRITE;
          tbl_value[k] = w.data_in;
          tbl_acks[k] = remote_nodes();
          tbl_slot[k] = {1'b0, w.buffer_slot};
          tbl_ver[k] = tbl_ver[k] + 32'd2;
          tbl_tie[k] = node_id;
          tbl_own_ver[k] = tbl_ver[k];
          tbl_own_tie[k] = node_id;
          r.status = RS_PUT_OK;
          r.out_version = tbl_ver[k];
          r.out_tie = node_id;
        end else begin
          r.status = RS_PUT_STALL;
        end
      end
      CMD_INV: begin
        r.status = RS_INV_OK;
        if (newer) begin
          tbl_writer[k] = w.sender;
          tbl_value[k] = w.data_in;
          if (st == KS_VALID) tbl_state[k] = KS_INVALID;
          else if (st == KS_WRITE || st == KS_REPLAY) tbl_state[k] = KS_INV_WRITE;
          tbl_ver[k] = w.ts_version;
          tbl_tie[k] = w.ts_tie;
        end else if (tbl_ver[k] == w.ts_version && tbl_tie[k] == w.ts_tie) begin
          if (st == KS_WRITE) r.status = RS_INV_OOG;
          tbl_writer[k] = w.sender;
        end
      end
      CMD_ACK: begin
        r.status = RS_ACK_OK;
        if (w.ts_version == tbl_own_ver[k] && w.ts_tie == tbl_own_tie[k]) begin
          tbl_acks[k][w.sender] = 1'b0;
          if ((tbl_acks[k] & alive) == 8'd0 && busy) begin
            r.completed = 1'b1;
            r.completed_slot = tbl_slot[k][5:0];
            tbl_slot[k] = 7'(SLOTS);
            if (st == KS_INV_WRITE) begin
              tbl_state[k] = KS_INVALID;
            end else if (st == KS_WRITE || st == KS_REPLAY) begin
              tbl_state[k] = KS_VALID;
              r.status = RS_LAST_ACK;
            end
          end
        end
      end
      CMD_VAL: begin
        r.status = RS_VAL_OK;
        if (tbl_ver[k] == w.ts_version && tbl_tie[k] == w.ts_tie)
          tbl_state[k] = KS_VALID;
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver: valid rises before the queue shrinks so waiters see a word in flight
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_ch.valid || in_fire) begin
        if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 15)) begin
          in_ch.valid = 1'b1;
          in_ch.payload = pending_words.pop_front();
        end else begin
          in_ch.valid = 1'b0;
        end
      end
      out_ch.ready <= calm || $urandom_range(99) >= 15;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    in_fire <= rst_ni && in_ch.valid && in_ch.ready;
    if (rst_ni && in_ch.valid && in_ch.ready)
      expected_words.push_back(apply_word(in_ch.payload));
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_ch.payload);
        errors <= errors + 1;
      end else if (out_ch.payload !== expected_words[0]) begin
        $display("%0t: expected %h actual %h", $time, expected_words[0], out_ch.payload);
        errors <= errors + 1;
        void'(expected_words.pop_front());
      end else begin
        void'(expected_words.pop_front());
      end
    end
    if (cycles > 400000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_NODE_ID) node_id = value[2:0];
    else alive = value;
  endtask

  task automatic drain();
    wait (pending_words.size() == 0 && !in_ch.valid && expected_words.size() == 0);
    repeat (6) @(negedge clk_i);
  endtask

  function automatic in_word_t random_word(int keybase);
    in_word_t w;
    int k;
    w.command = 3'($urandom_range(99) < 3 ? $urandom_range(7) : $urandom_range(4));
    w.key_index = 10'($urandom_range(99) < 5 ? $urandom_range(KEYS - 1) :
                      keybase + $urandom_range(KEY_POOL - 1));
    k = w.key_index;
    w.sender = 3'($urandom_range(7));
    w.data_in = {$urandom, $urandom};
    w.buffer_slot = 6'($urandom_range(SLOTS - 1));
    case ($urandom_range(5))
      0, 1: begin
        w.ts_version = tbl_own_ver[k];
        w.ts_tie = tbl_own_tie[k];
      end
      2: begin
        w.ts_version = tbl_ver[k];
        w.ts_tie = tbl_tie[k];
      end
      3: begin
        w.ts_version = tbl_ver[k] + 32'($urandom_range(3));
        w.ts_tie = 3'($urandom_range(7));
      end
      default: begin
        w.ts_version = $urandom;
        w.ts_tie = 3'($urandom_range(7));
      end
    endcase
    return w;
  endfunction

  task automatic run_random(int count, int keybase);
    in_word_t w;
    int k;
    for (int i = 0; i < count; i++) begin
      // predict from the state after everything queued so far
      wait (pending_words.size() == 0 && !in_ch.valid);
      w = random_word(keybase);
      k = w.key_index;
      if (w.command == CMD_ACK && $urandom_range(1) && tbl_acks[k] != 0)
        for (int n = 0; n < 8; n++) if (tbl_acks[k][n]) w.sender = 3'(n);
      pending_words.push_back(w);
      @(negedge clk_i);
    end
  endtask

  initial begin
    in_word_t w;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    for (int k = 0; k < KEYS; k++) begin
      tbl_state[k] = KS_VALID;
      tbl_ver[k] = '0; tbl_tie[k] = '0; tbl_writer[k] = '0; tbl_value[k] = '0;
      tbl_slot[k] = 7'(SLOTS); tbl_own_ver[k] = '0; tbl_own_tie[k] = '0;
      tbl_acks[k] = '0;
    end
    node_id = 3'd0;
    alive = 8'hff;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    write_reg(CFG_NODE_ID, 8'd7);
    write_reg(CFG_ALIVE, 8'h7f);
    calm = 1'b1;
    // directed: extremes, every command, unknown codes, wrap, departed writer
    w = '0;
    w.command = CMD_READ; w.key_index = 10'd1023; pending_words.push_back(w);
    w.command = CMD_WRITE; w.data_in = '1; w.buffer_slot = 6'd63; pending_words.push_back(w);
    w.command = CMD_WRITE; pending_words.push_back(w);
    w.command = CMD_READ; pending_words.push_back(w);
    w.command = CMD_INV; w.ts_version = 32'd2; w.ts_tie = 3'd7; w.sender = 3'd7;
    pending_words.push_back(w);
    w.command = CMD_ACK; w.sender = 3'd0; pending_words.push_back(w);
    for (int n = 1; n < 7; n++) begin
      w.sender = 3'(n); pending_words.push_back(w);
    end
    w.command = CMD_VAL; pending_words.push_back(w);
    w.key_index = 10'd0; w.command = CMD_INV; w.ts_version = 32'hffffffff;
    w.ts_tie = 3'd6; w.sender = 3'd7; w.data_in = 64'h8000_0000_0000_0001;
    pending_words.push_back(w);
    w.command = CMD_READ; w.buffer_slot = 6'd0; pending_words.push_back(w);
    w.command = CMD_READ; pending_words.push_back(w);
    w.command = CMD_WRITE; pending_words.push_back(w);
    for (int c = 5; c < 8; c++) begin
      w.command = 3'(c); pending_words.push_back(w);
    end
    w.command = CMD_VAL; w.ts_tie = 3'd7; pending_words.push_back(w);
    w.command = CMD_WRITE; w.key_index = 10'd5; pending_words.push_back(w);
    w.command = CMD_INV; w.ts_version = 32'hffffffff; w.ts_tie = 3'd7; w.sender = 3'd1;
    pending_words.push_back(w);
    w.command = CMD_INV; pending_words.push_back(w);
    drain();
    calm = 1'b0;
    write_reg(CFG_NODE_ID, 8'd0);
    write_reg(CFG_ALIVE, 8'hff);
    run_random(200, 16);
    drain();
    write_reg(CFG_NODE_ID, 8'd3);
    write_reg(CFG_ALIVE, 8'h0b);
    calm = 1'b1;
    run_random(150, 64);
    drain();
    calm = 1'b0;
    write_reg(CFG_ALIVE, 8'h00);
    run_random(150, 128);
    drain();
    write_reg(CFG_NODE_ID, 8'd5);
    write_reg(CFG_ALIVE, 8'h31);
    run_random(200, 256);
    drain();
    write_reg(CFG_ALIVE, 8'hff);
    run_random(200, 512);
    drain();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
sv/rkce_pkg.sv
sv/rkce_in_if.sv
sv/rkce_out_if.sv
sv/rkce_ctrl.sv
sv/rkce_dp.sv
sv/replicated_key_coherence_engine_top.sv
tb/replicated_key_coherence_engine_top_tb.sv
